// ===== rtl/wpf_pkg.sv =====
// Shared types and constants for the waveform peak finder.
package wpf_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int THRESH_W      = 10;
    localparam int PERIOD_W      = 8;
    localparam int TIME_W        = 16;
    localparam int PEAK_IDX_W    = 8;   // holds any sample index up to 256 samples
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 10;
    localparam int MAX_SAMPLES_D = 16;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 1'b0,
        REG_PERIOD    = 1'b1
    } t_cfg_reg;

    // Up to two peaks per input item: one closed by a rise, one closed by the last sample.
    typedef struct packed {
        logic                  close_valid;
        logic [PEAK_IDX_W-1:0] close_idx;
        logic [SAMPLE_W-1:0]   close_height;
        logic                  last_valid;
        logic [PEAK_IDX_W-1:0] last_idx;
        logic [SAMPLE_W-1:0]   last_height;
    } t_peak_cmd;

endpackage

// ===== rtl/wpf_front.sv =====
// Front end: accepts samples, tracks the open segment and issues peak commands.
module wpf_front
    import wpf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_D
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_last,
    input  logic [THRESH_W-1:0] i_threshold,
    input  logic                i_queue_full,
    output logic                o_push,
    output t_peak_cmd           o_cmd
);

    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(MAX_SAMPLES - 1);

    logic [SAMPLE_W-1:0] r_prev, n_prev;
    logic [SAMPLE_W-1:0] r_max, n_max;
    logic [IDX_W-1:0]    r_max_idx, n_max_idx;
    logic [IDX_W-1:0]    r_count, n_count;
    logic                r_falling, n_falling;
    logic                r_open, n_open;

    logic                accept;
    logic                fall;
    logic                rise;
    logic                falling_now;
    logic                close;
    logic [SAMPLE_W-1:0] drop;
    logic [SAMPLE_W-1:0] climb;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        drop        = r_prev - i_sample;
        climb       = i_sample - r_prev;
        fall        = (r_prev > i_sample) && (drop > i_threshold);
        rise        = (i_sample > r_prev) && (climb > i_threshold);
        falling_now = r_falling || fall;
        close       = r_open && falling_now && rise;

        n_prev    = r_prev;
        n_max     = r_max;
        n_max_idx = r_max_idx;
        n_falling = r_falling;
        n_open    = r_open;
        n_count   = r_count;

        o_cmd              = '0;
        o_cmd.close_valid  = close;
        o_cmd.close_idx    = PEAK_IDX_W'(r_max_idx);
        o_cmd.close_height = r_max;

        if (!r_open || close) begin
            n_prev    = i_sample;
            n_max     = i_sample;
            n_max_idx = r_count;
            n_falling = 1'b0;
            n_open    = 1'b1;
        end else begin
            if (i_sample > r_max) begin
                n_max     = i_sample;
                n_max_idx = r_count;
            end
            n_prev    = i_sample;
            n_falling = falling_now;
        end

        n_count = (r_count < IDX_SAT) ? r_count + 1'b1 : IDX_SAT;

        o_cmd.last_valid  = i_last;
        o_cmd.last_idx    = PEAK_IDX_W'(n_max_idx);
        o_cmd.last_height = n_max;

        if (i_last) begin
            n_open    = 1'b0;
            n_falling = 1'b0;
            n_count   = '0;
        end

        o_push = accept && (close || i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_max     <= '0;
            r_max_idx <= '0;
            r_count   <= '0;
            r_falling <= 1'b0;
            r_open    <= 1'b0;
        end else if (accept) begin
            r_prev    <= n_prev;
            r_max     <= n_max;
            r_max_idx <= n_max_idx;
            r_count   <= n_count;
            r_falling <= n_falling;
            r_open    <= n_open;
        end
    end

endmodule

// ===== rtl/wpf_queue.sv =====
// Short command queue between the front end and the output stage.
module wpf_queue
    import wpf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_peak_cmd i_cmd,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_peak_cmd o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_peak_cmd        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/wpf_back.sv =====
// Output stage: unrolls peak commands, scales time and drives the result stream.
module wpf_back
    import wpf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_peak_cmd           i_cmd,
    output logic                o_pop,
    input  logic [PERIOD_W-1:0] i_period,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [TIME_W-1:0]   o_time,
    output logic [SAMPLE_W-1:0] o_height,
    output logic                o_last
);

    t_peak_cmd             r_cmd;
    logic                  r_has_close;
    logic                  r_has_last;
    logic                  r_out_valid;
    logic [TIME_W-1:0]     r_out_time;
    logic [SAMPLE_W-1:0]   r_out_height;
    logic                  r_out_last;

    logic                  have;
    logic                  out_load;
    logic                  cmd_done;
    logic [PEAK_IDX_W-1:0] rec_idx;
    logic [SAMPLE_W-1:0]   rec_height;
    logic [TIME_W-1:0]     rec_time;

    always_comb begin
        have       = r_has_close || r_has_last;
        rec_idx    = r_has_close ? r_cmd.close_idx : r_cmd.last_idx;
        rec_height = r_has_close ? r_cmd.close_height : r_cmd.last_height;
        rec_time   = TIME_W'(rec_idx * i_period);
        out_load   = have && (!r_out_valid || i_ready);
        // done when no peak is pending, or once the only (or second) pending peak moves to the output register
        cmd_done   = !have || (out_load && !(r_has_close && r_has_last));
        o_pop      = cmd_done && i_cmd_valid;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (out_load) begin
            r_out_time   <= rec_time;
            r_out_height <= rec_height;
            r_out_last   <= !r_has_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_close <= 1'b0;
            r_has_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_has_close <= i_cmd.close_valid;
                r_has_last  <= i_cmd.last_valid;
            end else if (out_load) begin
                if (r_has_close) begin
                    r_has_close <= 1'b0;
                end else begin
                    r_has_last <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_time   = r_out_time;
    assign o_height = r_out_height;
    assign o_last   = r_out_last;

    a_no_empty_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_cmd.close_valid || i_cmd.last_valid))
        else $error("empty peak command taken from queue");

    a_close_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_has_close) |=> (r_out_valid && !r_out_last))
        else $error("rise-closed peak marked as final");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_has_close && r_has_last) |=> (r_out_valid && r_out_last))
        else $error("final peak not marked");

endmodule

// ===== rtl/waveform_peak_finder.sv =====
// Top level of the waveform peak finder: config registers and stream ports.
// Takes one sample per clock while the command queue is not full. Each peak result passes
// through the command queue write, the command register in the output stage and the
// output register with the index-times-period multiply. A sample that closes a
// peak by a rise and is also the last sample yields two results, which the single output
// register sends one after the other; the four-entry command queue absorbs
// that and any output stall, and the input stalls only when the queue is full.
// The config port is always ready; write it only while the block is idle.
module waveform_peak_finder
    import wpf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_D
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [9:0] adc_sample
    input  logic                   i_s_tlast,   // last_sample
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [15:0] peak_time, [25:16] peak_height
    output logic                   o_m_tlast,   // last_peak
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [THRESH_W-1:0] r_threshold;
    logic [PERIOD_W-1:0] r_period;

    logic                push;
    logic                queue_full;
    logic                pop;
    logic                cmd_valid;
    t_peak_cmd           cmd_in;
    t_peak_cmd           cmd_out;
    logic [TIME_W-1:0]   peak_time;
    logic [SAMPLE_W-1:0] peak_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_W'(12);
            r_period    <= PERIOD_W'(20);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_THRESHOLD: r_threshold <= i_cfg_data[THRESH_W-1:0];
                REG_PERIOD:    r_period    <= i_cfg_data[PERIOD_W-1:0];
                default:       ;
            endcase
        end
    end

    wpf_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_sample     (i_s_tdata[SAMPLE_W-1:0]),
        .i_last       (i_s_tlast),
        .i_threshold  (r_threshold),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (cmd_in)
    );

    wpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out)
    );

    wpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .i_period    (r_period),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_time      (peak_time),
        .o_height    (peak_height),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {(OUT_TDATA_W - TIME_W - SAMPLE_W)'(0), peak_height, peak_time};

endmodule
